// File: rtl/core/sslg_pkg.sv
// ----------------------------------------------------------------------------
// sslg_pkg
// Shared types, codes and the level table of the silence skip level gate.
// ----------------------------------------------------------------------------
`default_nettype none
package sslg_pkg;

  localparam int unsigned SumW  = 42;
  localparam int unsigned RmsW  = 16;
  localparam int unsigned LvlW  = 16;
  localparam int unsigned PosW  = 14;
  localparam int unsigned ActW  = 3;

  localparam logic [1:0] ModeFrame = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;

  localparam logic [2:0] CfgStart  = 3'd0;
  localparam logic [2:0] CfgMiddle = 3'd1;
  localparam logic [2:0] CfgEnd    = 3'd2;
  localparam logic [2:0] CfgLoop   = 3'd3;
  localparam logic [2:0] CfgChan   = 3'd4;

  localparam logic [2:0] ActNone   = 3'd0;
  localparam logic [2:0] ActSeekSt = 3'd1;
  localparam logic [2:0] ActNext   = 3'd2;
  localparam logic [2:0] ActReplay = 3'd3;
  localparam logic [2:0] ActSeekMd = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StRoot,
    StDecide,
    StOut
  } state_e;

  // lane sequencing: divide, then square root
  typedef enum logic [1:0] {
    LnIdle,
    LnDiv,
    LnSqrt,
    LnDone
  } lane_e;

  // lane control from the top level
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

  // Amplitude for threshold dB, clamped to -1..100.
  function automatic logic [15:0] amp_of(input logic signed [7:0] db);
    logic [6:0] idx;
    logic [15:0] v;
    begin
      if (db < -8'sd1) idx = 7'd0;
      else if (db > 8'sd100) idx = 7'd101;
      else idx = 7'(db + 8'sd1);
      unique case (idx)
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4: v = 16'd0;
        7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14: v = 16'd1;
        7'd15, 7'd16, 7'd17, 7'd18: v = 16'd2;
        7'd19, 7'd20, 7'd21: v = 16'd3;
        7'd22, 7'd23: v = 16'd4;
        7'd24, 7'd25: v = 16'd5;
        7'd26: v = 16'd6;
        7'd27, 7'd28: v = 16'd7;
        7'd29: v = 16'd8;   7'd30: v = 16'd9;   7'd31: v = 16'd10;
        7'd32: v = 16'd12;  7'd33: v = 16'd13;  7'd34: v = 16'd15;
        7'd35: v = 16'd16;  7'd36: v = 16'd18;  7'd37: v = 16'd21;
        7'd38: v = 16'd23;  7'd39: v = 16'd26;  7'd40: v = 16'd29;
        7'd41: v = 16'd33;  7'd42: v = 16'd37;  7'd43: v = 16'd41;
        7'd44: v = 16'd46;  7'd45: v = 16'd52;  7'd46: v = 16'd58;
        7'd47: v = 16'd65;  7'd48: v = 16'd73;  7'd49: v = 16'd82;
        7'd50: v = 16'd92;  7'd51: v = 16'd104; 7'd52: v = 16'd116;
        7'd53: v = 16'd130; 7'd54: v = 16'd146; 7'd55: v = 16'd164;
        7'd56: v = 16'd184; 7'd57: v = 16'd207; 7'd58: v = 16'd232;
        7'd59: v = 16'd260; 7'd60: v = 16'd292; 7'd61: v = 16'd328;
        7'd62: v = 16'd368; 7'd63: v = 16'd413; 7'd64: v = 16'd463;
        7'd65: v = 16'd519; 7'd66: v = 16'd583; 7'd67: v = 16'd654;
        7'd68: v = 16'd734; 7'd69: v = 16'd823; 7'd70: v = 16'd924;
        7'd71: v = 16'd1036; 7'd72: v = 16'd1163; 7'd73: v = 16'd1305;
        7'd74: v = 16'd1464; 7'd75: v = 16'd1642; 7'd76: v = 16'd1843;
        7'd77: v = 16'd2068; 7'd78: v = 16'd2320; 7'd79: v = 16'd2603;
        7'd80: v = 16'd2920; 7'd81: v = 16'd3277; 7'd82: v = 16'd3677;
        7'd83: v = 16'd4125; 7'd84: v = 16'd4629; 7'd85: v = 16'd5193;
        7'd86: v = 16'd5827; 7'd87: v = 16'd6538; 7'd88: v = 16'd7336;
        7'd89: v = 16'd8231; 7'd90: v = 16'd9235; 7'd91: v = 16'd10362;
        7'd92: v = 16'd11627; 7'd93: v = 16'd13045; 7'd94: v = 16'd14637;
        7'd95: v = 16'd16423; 7'd96: v = 16'd18427; 7'd97: v = 16'd20675;
        7'd98: v = 16'd23198; 7'd99: v = 16'd26029; 7'd100: v = 16'd29205;
        7'd101: v = 16'd32768;
        default: v = 16'd0;
      endcase
      amp_of = v;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/silence_skip_level_gate.sv
// ----------------------------------------------------------------------------
// silence_skip_level_gate
// Per-block RMS level of a stereo stream, gated against dB thresholds to
// choose skip, seek or track-change actions.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  in      | in_valid_i, in_stall_o, mode_i .. play_position_i | request in
//  out     | out_valid_o, out_stall_i, action_o, new_position_o | request out
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i               | write only
//
// Frames and song events are taken while the gate is idle. A closing frame
// runs a divide and then a square root in each lane, the lanes side by
// side, then a done state and a decide state: the request is registered
// at the decide, and input stalls from the closing frame until the decide.
// The decide state waits while the previous result is still held under
// out_stall_i; an unread result does not stall input otherwise.
// Reset clears sums, counts, flags and config to their defaults.
`default_nettype none
module silence_skip_level_gate #(
  parameter int unsigned MAX_BLOCK_FRAMES = 4096,
  parameter int unsigned LANES = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [15:0] left_sample_i,
  input  wire logic signed [15:0] right_sample_i,
  input  wire logic               last_of_block_i,
  input  wire logic [13:0]        play_position_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              action_o,
  output logic [13:0]             new_position_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);
  localparam int unsigned CntW = $clog2(MAX_BLOCK_FRAMES + 1);

  sslg_pkg::state_e st_q, st_d;

  logic signed [7:0] start_db_q, middle_db_q, end_db_q;
  logic              loop_q;
  logic [1:0]        chan_q;
  logic [CntW-1:0]   cnt_q;
  logic              sblk_q, eblk_q;
  logic [13:0]       pos_q;
  logic              ov_q;
  logic [2:0]        act_q;
  logic [13:0]       npos_q;

  logic              acc_go, fire, is_frame, acc, stereo, dec_go;
  logic [CntW-1:0]   div_n;
  logic [15:0]       rms_l, rms_r;
  logic              done_l, done_r, lanes_done;
  logic [2:0]        m_act;
  logic [13:0]       m_pos;
  logic              m_ss, m_se;
  sslg_pkg::lane_ctl_t ctl;

  assign in_stall_o  = (st_q != sslg_pkg::StIdle);
  assign fire        = in_valid_i && !in_stall_o;
  assign is_frame    = fire && (mode_i == sslg_pkg::ModeFrame);
  assign acc         = is_frame && (cnt_q < CntW'(MAX_BLOCK_FRAMES));
  assign acc_go      = is_frame && last_of_block_i;
  assign div_n       = (cnt_q == '0) ? CntW'(1) : cnt_q;
  assign stereo      = (LANES > 1) && chan_q[1];
  assign lanes_done  = done_l && done_r;
  // decide once the result register is free or is being read
  assign dec_go      = (st_q == sslg_pkg::StDecide) && (!ov_q || !out_stall_i);
  assign ctl.start   = acc_go;
  assign ctl.clear   = dec_go;

  // lane 0 always present, lane 1 as configured
  sslg_lane #(.CntW(CntW)) u_lane_l (
    .clk_i, .rst_ni, .acc_i(acc), .sample_i(left_sample_i), .ctl_i(ctl),
    .count_i(div_n), .rms_o(rms_l), .done_o(done_l)
  );

  if (LANES > 1) begin : g_right
    sslg_lane #(.CntW(CntW)) u_lane_r (
      .clk_i, .rst_ni, .acc_i(acc), .sample_i(right_sample_i), .ctl_i(ctl),
      .count_i(div_n), .rms_o(rms_r), .done_o(done_r)
    );
  end else begin : g_mono
    assign rms_r  = '0;
    assign done_r = 1'b1;
  end

  sslg_merge u_merge (
    .clk_i, .load_i(lanes_done), .rms_l_i(rms_l), .rms_r_i(rms_r),
    .stereo_i(stereo), .start_db_i(start_db_q), .middle_db_i(middle_db_q),
    .end_db_i(end_db_q), .loop_i(loop_q), .start_blk_i(sblk_q),
    .end_blk_i(eblk_q), .pos_i(pos_q), .action_o(m_act), .new_pos_o(m_pos),
    .set_start_o(m_ss), .set_end_o(m_se)
  );

  // sequence the block end
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sslg_pkg::StIdle:   if (acc_go) st_d = sslg_pkg::StRoot;
      sslg_pkg::StRoot:   if (lanes_done) st_d = sslg_pkg::StDecide;
      sslg_pkg::StDecide: if (dec_go) st_d = sslg_pkg::StIdle;
      sslg_pkg::StOut:    st_d = sslg_pkg::StIdle;
      default:            st_d = sslg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sslg_pkg::StIdle;
      start_db_q  <= 8'sd10;
      middle_db_q <= 8'sd0;
      end_db_q    <= 8'sd35;
      loop_q      <= 1'b0;
      chan_q      <= 2'd2;
      cnt_q       <= '0;
      sblk_q      <= 1'b0;
      eblk_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sslg_pkg::CfgStart:  start_db_q  <= cfg_data_i;
          sslg_pkg::CfgMiddle: middle_db_q <= cfg_data_i;
          sslg_pkg::CfgEnd:    end_db_q    <= cfg_data_i;
          sslg_pkg::CfgLoop:   loop_q      <= cfg_data_i[0];
          sslg_pkg::CfgChan:   chan_q      <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      // song events drive the block flags
      if (fire && mode_i == sslg_pkg::ModeStart) begin
        sblk_q <= 1'b0;
        eblk_q <= 1'b0;
      end else if (fire && mode_i == sslg_pkg::ModeEnd) begin
        sblk_q <= 1'b1;
        eblk_q <= 1'b1;
      end
      if (acc) cnt_q <= cnt_q + CntW'(1);
      if (dec_go) begin
        cnt_q <= '0;
        if (m_ss) sblk_q <= 1'b1;
        if (m_se) eblk_q <= 1'b1;
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // hold position and the result
  always_ff @(posedge clk_i) begin
    if (acc_go) pos_q <= play_position_i;
    if (dec_go) begin
      act_q  <= m_act;
      npos_q <= m_pos;
    end
  end

  assign out_valid_o    = ov_q;
  assign action_o       = act_q;
  assign new_position_o = npos_q;

endmodule
`default_nettype wire

// File: rtl/core/sslg_lane.sv
// ----------------------------------------------------------------------------
// sslg_lane
// One channel: square-sum accumulator, restoring divider by the frame count,
// then bit-pair square root, one bit per cycle each.
// ----------------------------------------------------------------------------
`default_nettype none
module sslg_lane #(
  parameter int unsigned CntW = 13
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire logic signed [15:0]            sample_i,
  input  wire sslg_pkg::lane_ctl_t           ctl_i,
  input  wire logic [CntW-1:0]               count_i,
  output logic [sslg_pkg::RmsW-1:0]          rms_o,
  output logic                               done_o
);
  localparam int unsigned SumW = sslg_pkg::SumW;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  sslg_pkg::lane_e   st_q, st_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [SumW-1:0]   quo_q;
  logic [CntW:0]     rem_q;
  logic [5:0]        step_q;
  logic [SumW+1:0]   rad_q;
  logic [SumW+1:0]   rem2_q;
  logic [21:0]       root_q;

  logic signed [31:0] smp_x;
  logic [31:0]       sq;
  logic [SumW:0]     sum_add;
  logic [CntW:0]     rem_sh;
  logic [SumW+1:0]   trial;
  logic [SumW+1:0]   r2_sh;

  assign smp_x   = 32'(sample_i);
  assign sq      = 32'(smp_x * smp_x);
  assign sum_add = {1'b0, sum_q} + {{(SumW-31){1'b0}}, sq};
  assign rem_sh  = {rem_q[CntW-1:0], quo_q[SumW-1]};
  assign r2_sh   = {rem2_q[SumW-1:0], rad_q[SumW+1:SumW]};
  assign trial   = {{(SumW-22){1'b0}}, root_q, 2'b01};

  // accumulate with saturation, clear after block end
  always_comb begin
    if (ctl_i.clear) sum_d = '0;
    else if (acc_i) sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    else sum_d = sum_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sslg_pkg::LnIdle: if (ctl_i.start) st_d = sslg_pkg::LnDiv;
      sslg_pkg::LnDiv:  if (step_q == 6'(SumW - 1)) st_d = sslg_pkg::LnSqrt;
      sslg_pkg::LnSqrt: if (step_q == 6'd21) st_d = sslg_pkg::LnDone;
      sslg_pkg::LnDone: st_d = sslg_pkg::LnIdle;
      default: st_d = sslg_pkg::LnIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= sslg_pkg::LnIdle;
      sum_q <= '0;
    end else begin
      st_q  <= st_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      sslg_pkg::LnIdle: begin
        // take the sum including a closing frame accepted at this edge
        quo_q  <= sum_d;
        rem_q  <= '0;
        step_q <= '0;
      end
      sslg_pkg::LnDiv: begin
        // restoring divide, one quotient bit a cycle
        if (rem_sh >= {1'b0, count_i}) begin
          rem_q <= rem_sh - {1'b0, count_i};
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
        if (step_q == 6'(SumW - 1)) begin
          step_q <= '0;
          rem2_q <= '0;
          root_q <= '0;
          rad_q  <= {2'b00, quo_q[SumW-2:0], (rem_sh >= {1'b0, count_i})};
        end else begin
          step_q <= step_q + 6'd1;
        end
      end
      sslg_pkg::LnSqrt: begin
        // one root bit per cycle from two radicand bits
        rad_q <= {rad_q[SumW-1:0], 2'b00};
        if (r2_sh >= trial) begin
          rem2_q <= r2_sh - trial;
          root_q <= {root_q[20:0], 1'b1};
        end else begin
          rem2_q <= r2_sh;
          root_q <= {root_q[20:0], 1'b0};
        end
        step_q <= step_q + 6'd1;
      end
      sslg_pkg::LnDone: ;
      default: ;
    endcase
  end

  assign done_o = (st_q == sslg_pkg::LnDone);
  assign rms_o  = (root_q > 22'd32768) ? 16'd32768 : root_q[15:0];

endmodule
`default_nettype wire

// File: rtl/core/sslg_merge.sv
// ----------------------------------------------------------------------------
// sslg_merge
// Combine lane levels into the average, or take the left level in mono, and pick the action for a block end.
// ----------------------------------------------------------------------------
`default_nettype none
module sslg_merge (
  input  wire logic                 clk_i,
  input  wire logic                 load_i,
  input  wire logic [15:0]          rms_l_i,
  input  wire logic [15:0]          rms_r_i,
  input  wire logic                 stereo_i,
  input  wire logic signed [7:0]    start_db_i,
  input  wire logic signed [7:0]    middle_db_i,
  input  wire logic signed [7:0]    end_db_i,
  input  wire logic                 loop_i,
  input  wire logic                 start_blk_i,
  input  wire logic                 end_blk_i,
  input  wire logic [13:0]          pos_i,
  output logic [2:0]                action_o,
  output logic [13:0]               new_pos_o,
  output logic                      set_start_o,
  output logic                      set_end_o
);
  logic [16:0] lvl_sum;
  logic [15:0] lvl_q;
  logic [14:0] p5, p10;
  logic        sb;

  assign lvl_sum = {1'b0, rms_l_i} + {1'b0, rms_r_i};

  // register the level, averaged in stereo
  always_ff @(posedge clk_i) begin
    if (load_i) lvl_q <= stereo_i ? lvl_sum[16:1] : rms_l_i;
  end

  assign p5  = {1'b0, pos_i} + 15'd5;
  assign p10 = {1'b0, pos_i} + 15'd10;

  always_comb begin
    action_o    = sslg_pkg::ActNone;
    new_pos_o   = '0;
    set_start_o = 1'b0;
    set_end_o   = 1'b0;
    sb          = start_blk_i;
    if (pos_i != 14'd0) begin
      if (lvl_q > sslg_pkg::amp_of(start_db_i)) begin
        set_start_o = 1'b1;
        sb          = 1'b1;
      end
      priority if (!start_db_i[7] && !sb && pos_i < 14'd1000) begin
        action_o  = sslg_pkg::ActSeekSt;
        new_pos_o = (p5 > 15'd10000) ? 14'd10000 : p5[13:0];
      end else if (!end_db_i[7] && !end_blk_i &&
                   lvl_q <= sslg_pkg::amp_of(end_db_i) && pos_i > 14'd9000) begin
        action_o  = loop_i ? sslg_pkg::ActReplay : sslg_pkg::ActNext;
        set_end_o = 1'b1;
      end else if (!middle_db_i[7] && lvl_q <= sslg_pkg::amp_of(middle_db_i) &&
                   pos_i >= 14'd1000 && pos_i <= 14'd9000) begin
        action_o  = sslg_pkg::ActSeekMd;
        new_pos_o = (p10 > 15'd10000) ? 14'd10000 : p10[13:0];
      end else begin
        action_o = sslg_pkg::ActNone;
      end
    end
  end

endmodule
`default_nettype wire
